>>> rtl/core/multi_queue_shared_buffer_core_macros.svh
// Assertion macros shared by the multi-queue shared buffer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTI_QUEUE_SHARED_BUFFER_CORE_MACROS_SVH
`define MULTI_QUEUE_SHARED_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MQSB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MQSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mqsb_pkg.sv
// Types, constants and helper functions for the multi-queue shared buffer.
// No dependencies; used by every module of the block.
package mqsb_pkg;

    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int NUM_QUEUES_DEF = 4;

    localparam int NUM_CFG  = 4;
    localparam int CFG_IW   = 2;
    localparam int SIZE_W   = 9;
    localparam int SIZE_MAX = 256;
    localparam int BASE_W   = 10;
    localparam int OFF_W    = 8;
    localparam int CNT_W    = 9;
    localparam int DATA_W   = 32;
    localparam int QI_W     = 2;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int TDATA_W  = 40;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INS          = 2'd0,
        KIND_DEL          = 2'd1,
        KIND_DEL_FULLEST  = 2'd2,
        KIND_INS_EMPTIEST = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic              is_ins;
        logic              auto_sel;
        logic [QI_W-1:0]   qidx;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef logic [NUM_CFG-1:0][SIZE_W-1:0] size_arr_t;
    typedef logic [NUM_CFG-1:0][BASE_W-1:0] base_arr_t;

    typedef struct packed {
        size_arr_t size;
        base_arr_t base;
    } cfg_t;

    localparam size_arr_t SIZE_RST = {9'd6, 9'd2, 9'd3, 9'd5};

    function automatic logic [SIZE_W-1:0] cap_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = (s > SIZE_W'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : s;
        return r;
    endfunction

    function automatic base_arr_t base_sums(input size_arr_t s);
        base_arr_t         b;
        logic [BASE_W:0]   acc;
        acc = '0;
        for (int i = 0; i < NUM_CFG; i++) begin
            b[i] = acc[BASE_W-1:0];
            acc  = acc + (BASE_W + 1)'(cap_size(s[i]));
        end
        return b;
    endfunction

endpackage

>>> rtl/core/multi_queue_shared_buffer_core.sv
// Multiple FIFO queues in one shared memory, each in a ring region sized over APB.
// A beat carries the operation in s_tuser and the queue index and data in s_tdata; every
// beat gives one result beat. In the execution stage an operation first picks the queue
// and updates its head and count, then does the memory access. An insert whose tail slot
// lies at or beyond twice a region that was shrunk while holding entries also passes
// through the remainder unit. A two-entry input queue and a result register let both
// sides stall independently. Memory contents are undefined until written; there is no
// clearing pass. Region bases are registered from the stored sizes after a size write.
module multi_queue_shared_buffer_core #(
    parameter int MEM_DEPTH  = mqsb_pkg::MEM_DEPTH_DEF,
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mqsb_pkg::PADDR_W-1:0]  paddr,
    input  logic [mqsb_pkg::PDATA_W-1:0]  pwdata,
    output logic [mqsb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mqsb_pkg::TDATA_W-1:0]  s_tdata,  // queue_index[1:0], data_in[33:2]
    input  logic [mqsb_pkg::KIND_W-1:0]   s_tuser,  // kind[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mqsb_pkg::TDATA_W-1:0]  m_tdata,  // queue_used[1:0], data_out[33:2]
    output logic [mqsb_pkg::STAT_W-1:0]   m_tuser   // status[1:0]
);

    mqsb_pkg::cfg_t cfg;
    mqsb_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    mqsb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mqsb_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mqsb_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/mqsb_cfg.sv
// APB register file holding the region sizes of the queues.
// Registers the capped sizes' running sums as region bases; uses mqsb_pkg.
module mqsb_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mqsb_pkg::PADDR_W-1:0]  paddr,
    input  logic [mqsb_pkg::PDATA_W-1:0]  pwdata,
    output logic [mqsb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output mqsb_pkg::cfg_t                cfg
);

    mqsb_pkg::size_arr_t size_reg;
    mqsb_pkg::size_arr_t size_next;
    mqsb_pkg::base_arr_t base_reg;
    logic [mqsb_pkg::CFG_IW-1:0] reg_idx;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[mqsb_pkg::CFG_IW+1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign prdata  = mqsb_pkg::PDATA_W'(size_reg[reg_idx]);

    always_comb
    begin
        size_next = size_reg;
        if (wr_en)
        begin
            size_next[reg_idx] = pwdata[mqsb_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= mqsb_pkg::SIZE_RST;
            base_reg <= mqsb_pkg::base_sums(mqsb_pkg::SIZE_RST);
        end
        else
        begin
            size_reg <= size_next;
            base_reg <= mqsb_pkg::base_sums(size_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < mqsb_pkg::NUM_CFG; i++)
        begin
            cfg.size[i] = mqsb_pkg::cap_size(size_reg[i]);
        end
        cfg.base = base_reg;
    end

endmodule

>>> rtl/core/mqsb_front.sv
// Input stage: decodes each beat into a command and holds it in a two-entry queue.
// Uses mqsb_pkg for the command type and operation codes.
module mqsb_front #(
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mqsb_pkg::TDATA_W-1:0]  s_tdata,
    input  logic [mqsb_pkg::KIND_W-1:0]   s_tuser,
    output logic                          cmd_valid,
    output mqsb_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    localparam int FQ_DEPTH = 2;
    localparam int FQ_PW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    mqsb_pkg::cmd_t              fq_reg [FQ_DEPTH];
    logic [FQ_PW-1:0]            wr_ptr_reg;
    logic [FQ_PW-1:0]            rd_ptr_reg;
    logic [FQ_CW-1:0]            fill_reg;
    mqsb_pkg::kind_t             kind;
    mqsb_pkg::cmd_t              dec;
    logic [mqsb_pkg::QI_W:0]     qw;
    logic                        push;

    assign s_tready  = (fill_reg != FQ_CW'(FQ_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = fq_reg[rd_ptr_reg];

    always_comb
    begin
        kind = mqsb_pkg::kind_t'(s_tuser);
        qw   = {1'b0, s_tdata[mqsb_pkg::QI_W-1:0]};
        if (qw >= (mqsb_pkg::QI_W + 1)'(NUM_QUEUES))
        begin
            qw = qw - (mqsb_pkg::QI_W + 1)'(NUM_QUEUES);
        end
        dec.is_ins   = (kind == mqsb_pkg::KIND_INS) || (kind == mqsb_pkg::KIND_INS_EMPTIEST);
        dec.auto_sel = (kind == mqsb_pkg::KIND_DEL_FULLEST)
                    || (kind == mqsb_pkg::KIND_INS_EMPTIEST);
        dec.qidx     = qw[mqsb_pkg::QI_W-1:0];
        dec.data     = s_tdata[mqsb_pkg::QI_W +: mqsb_pkg::DATA_W];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FQ_PW'(1);
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FQ_PW'(1);
            end
            if (push && !cmd_pop)
            begin
                fill_reg <= fill_reg + FQ_CW'(1);
            end
            else if (!push && cmd_pop)
            begin
                fill_reg <= fill_reg - FQ_CW'(1);
            end
        end
    end

endmodule

>>> rtl/core/mqsb_rem.sv
// Iterative remainder unit, one quotient bit per cycle (restoring).
// Used by the back end to fold a tail offset into a shrunk region; uses mqsb_pkg.
module mqsb_rem
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mqsb_pkg::SIZE_W-1:0]  dividend,
    input  logic [mqsb_pkg::SIZE_W-1:0]  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [mqsb_pkg::SIZE_W-1:0]  result
);

    localparam int DW = mqsb_pkg::SIZE_W;
    localparam int SW = $clog2(DW + 1);

    logic [DW-1:0] acc_reg;
    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] dvs_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW-1:0] acc_next;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

    always_comb
    begin
        trial = {acc_reg, dvd_reg[DW-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            acc_next = DW'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            acc_next = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            acc_reg  <= '0;
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            step_reg <= SW'(DW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            dvd_reg  <= dvd_reg << 1;
            step_reg <= step_reg - SW'(1);
            if (step_reg == SW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/mqsb_back.sv
// Execution stage: queue choice, head and count update, shared memory access, result register.
// Uses mqsb_pkg, mqsb_rem and the assertion macros header.
`include "multi_queue_shared_buffer_core_macros.svh"

module mqsb_back #(
    parameter int MEM_DEPTH  = mqsb_pkg::MEM_DEPTH_DEF,
    parameter int NUM_QUEUES = mqsb_pkg::NUM_QUEUES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mqsb_pkg::cfg_t                cfg,
    input  logic                          cmd_valid,
    input  mqsb_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mqsb_pkg::TDATA_W-1:0]  m_tdata,
    output logic [mqsb_pkg::STAT_W-1:0]   m_tuser
);

    localparam int QIW = $clog2(NUM_QUEUES);
    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int BW  = mqsb_pkg::BASE_W;
    localparam int SZW = mqsb_pkg::SIZE_W;
    localparam int OW  = mqsb_pkg::OFF_W;
    localparam int CW  = mqsb_pkg::CNT_W;
    localparam int DW  = mqsb_pkg::DATA_W;
    localparam int PADW = mqsb_pkg::TDATA_W - DW - mqsb_pkg::QI_W;

    typedef enum logic [1:0] {
        S_SEL,
        S_REM,
        S_MEM
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               cnt_reg  [NUM_QUEUES];
    logic [CW-1:0]               cnt_next [NUM_QUEUES];
    logic [OW-1:0]               head_reg  [NUM_QUEUES];
    logic [OW-1:0]               head_next [NUM_QUEUES];
    logic [QIW-1:0]              q_reg, q_next;
    logic                        ins_reg, ins_next;
    logic                        ok_reg, ok_next;
    mqsb_pkg::status_t           st_reg, st_next;
    logic [OW-1:0]               off_reg, off_next;
    logic [DW-1:0]               data_reg, data_next;
    logic                        pend_reg, pend_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [mqsb_pkg::TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    mqsb_pkg::status_t           m_tuser_reg, m_tuser_next;
    logic [DW-1:0]               rd_reg;
    logic [DW-1:0]               mem [MEM_DEPTH];

    logic [QIW-1:0]              sel_q;
    logic [CW-1:0]               cur_cnt;
    logic [OW-1:0]               cur_head;
    logic [SZW-1:0]              cur_sz;
    logic                        full;
    logic                        empty;
    logic [SZW-1:0]              tail_sum;
    logic [SZW-1:0]              tail_sub;
    logic                        tail_lt1;
    logic                        tail_lt2;
    logic [SZW-1:0]              head_inc;
    logic [OW-1:0]               head_wrap;
    logic                        out_load;
    logic                        rem_start;
    logic                        rem_busy;
    logic                        rem_done;
    logic [SZW-1:0]              rem_result;
    logic [BW-1:0]               mem_sum;
    logic [AW-1:0]               mem_addr;
    logic [DW-1:0]               out_data;

    mqsb_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (tail_sum),
        .divisor  (cur_sz),
        .busy     (rem_busy),
        .done     (rem_done),
        .result   (rem_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Resolve target queue; ties go to the later queue.
    always_comb
    begin
        if (cmd.auto_sel)
        begin
            sel_q = '0;
            for (int i = 1; i < NUM_QUEUES; i++)
            begin
                if (cmd.is_ins ? (cnt_reg[i] <= cnt_reg[sel_q])
                               : (cnt_reg[i] >= cnt_reg[sel_q]))
                begin
                    sel_q = QIW'(i);
                end
            end
        end
        else
        begin
            sel_q = QIW'(cmd.qidx);
        end
        cur_cnt   = cnt_reg[sel_q];
        cur_head  = head_reg[sel_q];
        cur_sz    = cfg.size[mqsb_pkg::CFG_IW'(sel_q)];
        full      = (cur_cnt >= cur_sz);
        empty     = (cur_cnt == '0);
        tail_sum  = SZW'({1'b0, cur_head}) + SZW'(cur_cnt);
        tail_sub  = tail_sum - cur_sz;
        tail_lt1  = (tail_sum < cur_sz);
        tail_lt2  = ({1'b0, tail_sum} < {cur_sz, 1'b0});
        head_inc  = SZW'({1'b0, cur_head}) + SZW'(1);
        head_wrap = (head_inc >= cur_sz) ? '0 : head_inc[OW-1:0];
    end

    // Fold base plus offset into the memory, one compare and subtract per power of two.
    always_comb
    begin
        mem_sum = cfg.base[mqsb_pkg::CFG_IW'(q_reg)] + BW'(off_reg);
        for (int k = BW - 1; k >= 0; k--)
        begin
            if ((MEM_DEPTH << k) < (1 << BW))
            begin
                if (mem_sum >= BW'(MEM_DEPTH << k))
                begin
                    mem_sum = mem_sum - BW'(MEM_DEPTH << k);
                end
            end
        end
        mem_addr = AW'(mem_sum);
    end

    assign out_data = (ok_reg && !ins_reg) ? rd_reg : '0;
    assign out_load = pend_reg && (!m_tvalid_reg || m_tready);
    assign cmd_pop  = (state_reg == S_SEL) && cmd_valid && (!pend_reg || out_load);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        q_next        = q_reg;
        ins_next      = ins_reg;
        ok_next       = ok_reg;
        st_next       = st_reg;
        off_next      = off_reg;
        data_next     = data_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rem_start     = 1'b0;

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {PADW'(0), out_data, mqsb_pkg::QI_W'(q_reg)};
            m_tuser_next  = st_reg;
            pend_next     = 1'b0;
        end
        else if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_SEL:
            begin
                if (cmd_pop)
                begin
                    q_next     = sel_q;
                    ins_next   = cmd.is_ins;
                    data_next  = cmd.data;
                    state_next = S_MEM;
                    if (cmd.is_ins)
                    begin
                        if (full)
                        begin
                            ok_next = 1'b0;
                            st_next = mqsb_pkg::ST_FULL;
                        end
                        else
                        begin
                            ok_next         = 1'b1;
                            st_next         = mqsb_pkg::ST_OK;
                            cnt_next[sel_q] = cur_cnt + CW'(1);
                            off_next        = tail_lt1 ? tail_sum[OW-1:0] : tail_sub[OW-1:0];
                            if (!tail_lt2)
                            begin
                                rem_start  = 1'b1;
                                state_next = S_REM;
                            end
                        end
                    end
                    else
                    begin
                        if (empty)
                        begin
                            ok_next = 1'b0;
                            st_next = mqsb_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ok_next          = 1'b1;
                            st_next          = mqsb_pkg::ST_OK;
                            off_next         = cur_head;
                            head_next[sel_q] = head_wrap;
                            cnt_next[sel_q]  = cur_cnt - CW'(1);
                        end
                    end
                end
            end
            S_REM:
            begin
                if (rem_done)
                begin
                    off_next   = OW'(rem_result);
                    state_next = S_MEM;
                end
            end
            S_MEM:
            begin
                pend_next  = 1'b1;
                state_next = S_SEL;
            end
            default:
            begin
                state_next = S_SEL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SEL;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
            q_reg        <= '0;
            ins_reg      <= 1'b0;
            ok_reg       <= 1'b0;
            st_reg       <= mqsb_pkg::ST_OK;
            off_reg      <= '0;
            data_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= mqsb_pkg::ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            q_reg        <= q_next;
            ins_reg      <= ins_next;
            ok_reg       <= ok_next;
            st_reg       <= st_next;
            off_reg      <= off_next;
            data_reg     <= data_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_MEM) && ok_reg)
        begin
            if (ins_reg)
            begin
                mem[mem_addr] <= data_reg;
            end
            else
            begin
                rd_reg <= mem[mem_addr];
            end
        end
    end

    `MQSB_ASSERT_IMPL(a_pop_needs_slot, cmd_pop, !pend_reg || out_load, "command taken while result slot occupied")
    `MQSB_ASSERT_NEXT(a_pend_held, pend_reg && !out_load, pend_reg, "pending result dropped")
    `MQSB_ASSERT_IMPL(a_rem_in_wrap, rem_busy, state_reg == S_REM, "remainder unit busy outside wrap state")
    `MQSB_ASSERT_IMPL(a_ins_counted, (state_reg == S_MEM) && ok_reg && ins_reg, cnt_reg[q_reg] != '0, "insert not counted")

endmodule
